// ----- rtl/core/ecpr_pkg.sv -----
// Shared types and constants for the enhanced clock page replacement block.
// No dependencies; imported by the core and its checker.
package ecpr_pkg;

   localparam int DEF_MAX_FRAMES = 8;
   localparam int DEF_PAGE_COUNT = 64;

   localparam int PAGE_W  = 6;
   localparam int CFG_W   = 4;
   localparam int FCNT_W  = 16;

   localparam logic [CFG_W-1:0]  CFG_RESET = 4'd5;
   localparam logic [FCNT_W-1:0] FCNT_MAX  = '1;

   // pass codes of the victim scan
   localparam logic [1:0] PASS_LAST = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_HIT,
      ST_MISS,
      ST_SCAN,
      ST_EVICT,
      ST_REPLACE,
      ST_DONE
   } state_type;

endpackage

// ----- rtl/core/enhanced_clock_page_replacement.sv -----
// Enhanced second-chance clock page replacement core.
// Depends on ecpr_pkg; one module with a registered-read page table.
//
// One page reference per transaction; req_ready is high only while the core is idle.
// A request first walks the filled frames through the page table read port, one frame
// per cycle. A miss with free frames left takes the next free frame. A replacement
// fault then runs the clock scan over the reference and modify bits, one frame per
// cycle; a victim always turns up by the first frame of the fourth pass. The
// result sits in an output register, so the next request is accepted while an earlier
// result waits; a finished transaction only stalls while that register is still full.
module enhanced_clock_page_replacement
   import ecpr_pkg::*;
#(
   parameter int MAX_FRAMES = DEF_MAX_FRAMES,
   parameter int PAGE_COUNT = DEF_PAGE_COUNT,
   localparam int FW = $clog2(MAX_FRAMES),
   localparam int CW = $clog2(MAX_FRAMES + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [CFG_W-1:0]    csr_wr_data,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [PAGE_W-1:0]   req_page,
   input  logic                req_is_write,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_hit,
   output logic                rsp_fault,
   output logic [FW-1:0]       rsp_frame,
   output logic [PAGE_W-1:0]   rsp_evicted_page,
   output logic                rsp_evicted_dirty,
   output logic [FCNT_W-1:0]   rsp_fault_total
);

   localparam int AW        = (CW > CFG_W) ? CW : CFG_W;
   localparam int PAGE_SPAN = 2 ** PAGE_W;

   // page number wrap, worked out at elaboration
   logic [PAGE_W-1:0] page_wrap [PAGE_SPAN];
   for (genvar g = 0; g < PAGE_SPAN; g++) begin : g_wrap
      assign page_wrap[g] = PAGE_W'(g % PAGE_COUNT);
   end

   // page table memory
   logic [PAGE_W-1:0] mem [MAX_FRAMES];
   logic              mem_we;
   logic [FW-1:0]     mem_waddr;
   logic [PAGE_W-1:0] rd_data_ff;

   // control state
   state_type          state_ff, state_in;
   logic [CFG_W-1:0]   cfg_ff, cfg_in;
   logic               ref_ff [MAX_FRAMES];
   logic               ref_in [MAX_FRAMES];
   logic               dirty_ff [MAX_FRAMES];
   logic               dirty_in [MAX_FRAMES];
   logic [CW-1:0]      filled_ff, filled_in;
   logic [FW-1:0]      hand_ff, hand_in;
   logic [FCNT_W-1:0]  fcnt_ff, fcnt_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // per-transaction working registers
   logic [PAGE_W-1:0]  page_ff, page_in;
   logic               wr_ff, wr_in;
   logic [CW-1:0]      n_ff, n_in;
   logic [CW-1:0]      used_ff, used_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic               cmp_vld_ff, cmp_vld_in;
   logic [FW-1:0]      cmp_idx_ff, cmp_idx_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [1:0]         pass_ff, pass_in;
   logic [FW-1:0]      start_ff, start_in;
   logic [FW-1:0]      frame_ff, frame_in;
   logic               hit_ff, hit_in;
   logic               fault_ff, fault_in;
   logic [PAGE_W-1:0]  ev_page_ff, ev_page_in;
   logic               ev_dirty_ff, ev_dirty_in;

   // result register
   logic               rsp_hit_ff, rsp_hit_in;
   logic               rsp_fault_ff, rsp_fault_in;
   logic [FW-1:0]      rsp_frame_ff, rsp_frame_in;
   logic [PAGE_W-1:0]  rsp_ev_page_ff, rsp_ev_page_in;
   logic               rsp_ev_dirty_ff, rsp_ev_dirty_in;
   logic [FCNT_W-1:0]  rsp_ftot_ff, rsp_ftot_in;

   // shared scan helpers
   logic [AW-1:0]  cfg_wide;
   logic [CW-1:0]  n_now;
   logic [FW-1:0]  sidx;
   logic [CW-1:0]  idx_inc;
   logic [FW-1:0]  idx_wrap;
   logic           scan_found;
   logic           scan_last;
   logic           slot_free;

   assign cfg_wide = AW'(cfg_ff);
   always_comb begin
      if (cfg_ff == '0) begin
         n_now = CW'(1);
      end else if (cfg_wide > AW'(MAX_FRAMES)) begin
         n_now = CW'(MAX_FRAMES);
      end else begin
         n_now = CW'(cfg_wide);
      end
   end

   assign sidx       = idx_ff[FW-1:0];
   assign idx_inc    = idx_ff + CW'(1);
   assign idx_wrap   = (idx_inc == n_ff) ? '0 : idx_inc[FW-1:0];
   assign scan_found = !ref_ff[sidx] && (dirty_ff[sidx] == pass_ff[0]);
   assign scan_last  = (cnt_ff == n_ff - CW'(1));
   assign slot_free  = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SEARCH;
         end
         ST_SEARCH: begin
            if (cmp_vld_ff && rd_data_ff == page_ff) begin
               state_in = ST_HIT;
            end else if (!cmp_vld_ff && idx_ff == used_ff) begin
               state_in = ST_MISS;
            end
         end
         ST_HIT: begin
            state_in = ST_DONE;
         end
         ST_MISS: begin
            state_in = (filled_ff < n_ff) ? ST_DONE : ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_found) begin
               state_in = ST_REPLACE;
            end else if (pass_ff == PASS_LAST && scan_last) begin
               state_in = ST_EVICT;
            end
         end
         ST_EVICT: begin
            state_in = ST_REPLACE;
         end
         ST_REPLACE: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      cfg_in          = csr_wr_en ? csr_wr_data : cfg_ff;
      ref_in          = ref_ff;
      dirty_in        = dirty_ff;
      filled_in       = filled_ff;
      hand_in         = hand_ff;
      fcnt_in         = fcnt_ff;
      page_in         = page_ff;
      wr_in           = wr_ff;
      n_in            = n_ff;
      used_in         = used_ff;
      idx_in          = idx_ff;
      cmp_vld_in      = cmp_vld_ff;
      cmp_idx_in      = cmp_idx_ff;
      cnt_in          = cnt_ff;
      pass_in         = pass_ff;
      start_in        = start_ff;
      frame_in        = frame_ff;
      hit_in          = hit_ff;
      fault_in        = fault_ff;
      ev_page_in      = ev_page_ff;
      ev_dirty_in     = ev_dirty_ff;
      mem_we          = 1'b0;
      mem_waddr       = sidx;
      rsp_hit_in      = rsp_hit_ff;
      rsp_fault_in    = rsp_fault_ff;
      rsp_frame_in    = rsp_frame_ff;
      rsp_ev_page_in  = rsp_ev_page_ff;
      rsp_ev_dirty_in = rsp_ev_dirty_ff;
      rsp_ftot_in     = rsp_ftot_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      req_ready       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            page_in     = page_wrap[req_page];
            wr_in       = req_is_write;
            n_in        = n_now;
            used_in     = (filled_ff < n_now) ? filled_ff : n_now;
            idx_in      = '0;
            cmp_vld_in  = 1'b0;
            hit_in      = 1'b0;
            fault_in    = 1'b0;
            ev_page_in  = '0;
            ev_dirty_in = 1'b0;
         end
         ST_SEARCH: begin
            // read of idx issued this cycle, compare of the previous read
            if (cmp_vld_ff && rd_data_ff == page_ff) begin
               frame_in = cmp_idx_ff;
               hit_in   = 1'b1;
            end else if (idx_ff != used_ff) begin
               cmp_vld_in = 1'b1;
               cmp_idx_in = sidx;
               idx_in     = idx_inc;
            end else begin
               cmp_vld_in = 1'b0;
            end
         end
         ST_HIT: begin
            ref_in[frame_ff]   = 1'b1;
            dirty_in[frame_ff] = dirty_ff[frame_ff] | wr_ff;
         end
         ST_MISS: begin
            if (filled_ff < n_ff) begin
               frame_in            = filled_ff[FW-1:0];
               mem_we              = 1'b1;
               mem_waddr           = filled_ff[FW-1:0];
               ref_in[filled_ff[FW-1:0]]   = 1'b1;
               dirty_in[filled_ff[FW-1:0]] = wr_ff;
               filled_in           = filled_ff + CW'(1);
            end else begin
               fault_in = 1'b1;
               if (fcnt_ff != FCNT_MAX) fcnt_in = fcnt_ff + FCNT_W'(1);
               start_in = (CW'(hand_ff) < n_ff) ? hand_ff : '0;
               idx_in   = (CW'(hand_ff) < n_ff) ? CW'(hand_ff) : '0;
               cnt_in   = '0;
               pass_in  = '0;
            end
         end
         ST_SCAN: begin
            if (!scan_found) begin
               // odd passes strip the second chance as they go
               if (pass_ff[0]) ref_in[sidx] = 1'b0;
               if (pass_ff == PASS_LAST && scan_last) begin
                  idx_in = CW'(start_ff);
               end else begin
                  idx_in = CW'(idx_wrap);
                  if (scan_last) begin
                     cnt_in  = '0;
                     pass_in = pass_ff + 2'd1;
                  end else begin
                     cnt_in = cnt_ff + CW'(1);
                  end
               end
            end
         end
         ST_EVICT: begin
            // wait for the victim's table read
         end
         ST_REPLACE: begin
            frame_in       = sidx;
            ev_page_in     = rd_data_ff;
            ev_dirty_in    = dirty_ff[sidx];
            mem_we         = 1'b1;
            mem_waddr      = sidx;
            ref_in[sidx]   = 1'b1;
            dirty_in[sidx] = wr_ff;
            hand_in        = idx_wrap;
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in    = 1'b1;
               rsp_hit_in      = hit_ff;
               rsp_fault_in    = fault_ff;
               rsp_frame_in    = frame_ff;
               rsp_ev_page_in  = ev_page_ff;
               rsp_ev_dirty_in = ev_dirty_ff;
               rsp_ftot_in     = fcnt_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // page table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= page_ff;
      rd_data_ff <= mem[sidx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cfg_ff       <= CFG_RESET;
         filled_ff    <= '0;
         hand_ff      <= '0;
         fcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_FRAMES; i++) begin
            ref_ff[i]   <= 1'b0;
            dirty_ff[i] <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         cfg_ff       <= cfg_in;
         filled_ff    <= filled_in;
         hand_ff      <= hand_in;
         fcnt_ff      <= fcnt_in;
         rsp_valid_ff <= rsp_valid_in;
         ref_ff       <= ref_in;
         dirty_ff     <= dirty_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff         <= page_in;
      wr_ff           <= wr_in;
      n_ff            <= n_in;
      used_ff         <= used_in;
      idx_ff          <= idx_in;
      cmp_vld_ff      <= cmp_vld_in;
      cmp_idx_ff      <= cmp_idx_in;
      cnt_ff          <= cnt_in;
      pass_ff         <= pass_in;
      start_ff        <= start_in;
      frame_ff        <= frame_in;
      hit_ff          <= hit_in;
      fault_ff        <= fault_in;
      ev_page_ff      <= ev_page_in;
      ev_dirty_ff     <= ev_dirty_in;
      rsp_hit_ff      <= rsp_hit_in;
      rsp_fault_ff    <= rsp_fault_in;
      rsp_frame_ff    <= rsp_frame_in;
      rsp_ev_page_ff  <= rsp_ev_page_in;
      rsp_ev_dirty_ff <= rsp_ev_dirty_in;
      rsp_ftot_ff     <= rsp_ftot_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_fault         = rsp_fault_ff;
   assign rsp_frame         = rsp_frame_ff;
   assign rsp_evicted_page  = rsp_ev_page_ff;
   assign rsp_evicted_dirty = rsp_ev_dirty_ff;
   assign rsp_fault_total   = rsp_ftot_ff;

endmodule

// ----- rtl/core/ecpr_checker.sv -----
// Port-level checks for the enhanced clock page replacement core.
// Depends on ecpr_pkg; bound to enhanced_clock_page_replacement below.
module ecpr_checker
   import ecpr_pkg::*;
#(
   parameter int MAX_FRAMES = DEF_MAX_FRAMES,
   localparam int FW = $clog2(MAX_FRAMES)
) (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic                rsp_hit,
   input logic                rsp_fault,
   input logic [FW-1:0]       rsp_frame,
   input logic [PAGE_W-1:0]   rsp_evicted_page,
   input logic                rsp_evicted_dirty,
   input logic [FCNT_W-1:0]   rsp_fault_total
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_frame)
         && $stable(rsp_fault_total) && $stable(rsp_hit))
      else $error("response changed while stalled");

   a_hit_xor_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_hit && rsp_fault))
      else $error("hit and fault both set");

   a_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_fault |-> rsp_evicted_page == '0 && !rsp_evicted_dirty)
      else $error("eviction reported without a fault");

   a_fault_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fault |-> rsp_fault_total != '0)
      else $error("fault transaction with zero fault total");

endmodule

bind enhanced_clock_page_replacement ecpr_checker #(.MAX_FRAMES(MAX_FRAMES)) u_ecpr_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_hit           (rsp_hit),
   .rsp_fault         (rsp_fault),
   .rsp_frame         (rsp_frame),
   .rsp_evicted_page  (rsp_evicted_page),
   .rsp_evicted_dirty (rsp_evicted_dirty),
   .rsp_fault_total   (rsp_fault_total)
);
